[hdl/drialloc_pkg.sv]
// -----------------------------------------------------------------------------
// drialloc_pkg
// Shared types, codes and the control store of the deferred release allocator.
// -----------------------------------------------------------------------------
package drialloc_pkg;

    typedef struct packed {
        logic [1:0]  kind;
        logic [8:0]  handle;
        logic [31:0] current_frame;
        logic [31:0] completed_frame;
        logic        force_all;
    } t_in;

    typedef struct packed {
        logic [8:0] granted_handle;
        logic [1:0] status;
        logic [8:0] reclaimed_count;
        logic [8:0] free_count;
        logic [8:0] pending_count;
    } t_out;

    localparam logic [1:0] KIND_ACQUIRE = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_TICK    = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;
    localparam logic [1:0] ST_DROPPED = 2'd3;

    localparam logic [2:0] ADDR_ENABLED  = 3'h0;
    localparam logic [2:0] ADDR_CAPACITY = 3'h4;

    typedef logic [3:0] t_upc;

    localparam t_upc UA_FETCH     = 4'd0;
    localparam t_upc UA_ACQ_CHK   = 4'd1;
    localparam t_upc UA_ACQ_GNT   = 4'd2;
    localparam t_upc UA_REL       = 4'd3;
    localparam t_upc UA_TICK_INIT = 4'd4;
    localparam t_upc UA_TICK_STEP = 4'd5;
    localparam t_upc UA_TICK_END  = 4'd6;
    localparam t_upc UA_BAD       = 4'd7;
    localparam t_upc UA_EMIT      = 4'd8;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LATCH,
        OP_ACQ_CHECK,
        OP_ACQ_GRANT,
        OP_REL,
        OP_TICK_INIT,
        OP_TICK_STEP,
        OP_TICK_END,
        OP_BAD,
        OP_EMIT
    } t_uop;

    typedef enum logic [2:0] {
        CD_NEXT,
        CD_JUMP,
        CD_FLAG,
        CD_LOOP,
        CD_INPUT,
        CD_OUTPUT
    } t_cond;

    typedef struct packed {
        t_cond cond;
        t_upc  target;
        t_uop  op;
    } t_ctrl;

    function automatic t_ctrl ucode(input t_upc addr);
        t_ctrl w;
        case (addr)
            UA_FETCH:     w = '{cond: CD_INPUT,  target: UA_FETCH,     op: OP_LATCH};
            UA_ACQ_CHK:   w = '{cond: CD_FLAG,   target: UA_EMIT,      op: OP_ACQ_CHECK};
            UA_ACQ_GNT:   w = '{cond: CD_JUMP,   target: UA_EMIT,      op: OP_ACQ_GRANT};
            UA_REL:       w = '{cond: CD_JUMP,   target: UA_EMIT,      op: OP_REL};
            UA_TICK_INIT: w = '{cond: CD_FLAG,   target: UA_EMIT,      op: OP_TICK_INIT};
            UA_TICK_STEP: w = '{cond: CD_LOOP,   target: UA_TICK_STEP, op: OP_TICK_STEP};
            UA_TICK_END:  w = '{cond: CD_JUMP,   target: UA_EMIT,      op: OP_TICK_END};
            UA_BAD:       w = '{cond: CD_JUMP,   target: UA_EMIT,      op: OP_BAD};
            UA_EMIT:      w = '{cond: CD_OUTPUT, target: UA_FETCH,     op: OP_EMIT};
            default:      w = '{cond: CD_JUMP,   target: UA_FETCH,     op: OP_NONE};
        endcase
        return w;
    endfunction

endpackage

[hdl/drialloc_ram.sv]
// -----------------------------------------------------------------------------
// drialloc_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// -----------------------------------------------------------------------------
module drialloc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/deferred_release_index_allocator_core.sv]
// -----------------------------------------------------------------------------
// deferred_release_index_allocator_core
// Slot allocator with a FIFO free list and a frame-stamped pending list,
// run by a microcoded sequencer over two RAMs.
// -----------------------------------------------------------------------------
// Sequence: acquire = check, grant, emit; refused acquire, release, unused kind = one
//   step, emit; tick = init, a step per pending entry, end, emit (init, emit if none).
// Throughput: one transaction at a time, the next taken once the result is registered;
//   a tick walks the pending RAM one entry per cycle. A result held in the output
//   register stalls the program.
// Reset: enabled set, capacity min(256, POOL_DEPTH), free list 0..capacity-1,
//   pending list empty; no clearing pass, usable on the first cycle.
// -----------------------------------------------------------------------------
module deferred_release_index_allocator_core #(
    parameter int POOL_DEPTH = 256,
    parameter int FRAME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  drialloc_pkg::t_in    i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output drialloc_pkg::t_out   o_out,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int IDX_W   = $clog2(POOL_DEPTH);
    localparam int LVL_W   = $clog2(POOL_DEPTH + 1);
    localparam int STAMP_W = (FRAME_BITS < 32) ? FRAME_BITS : 32;
    localparam int PEND_W  = IDX_W + STAMP_W;
    localparam int CMP_W   = (LVL_W > 9) ? LVL_W : 9;
    localparam int CAP_RST = (POOL_DEPTH < 256) ? POOL_DEPTH : 256;

    drialloc_pkg::t_upc  r_upc, n_upc;
    drialloc_pkg::t_ctrl ctrl;
    drialloc_pkg::t_in   r_in, n_in;
    drialloc_pkg::t_out  r_out, n_out;

    logic               r_out_valid, n_out_valid;
    logic               r_en, n_en;
    logic [LVL_W-1:0]   r_cap, n_cap;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [LVL_W-1:0]   r_free_lvl, n_free_lvl;
    logic [LVL_W-1:0]   r_fill, n_fill;
    logic [LVL_W-1:0]   r_pend_lvl, n_pend_lvl;
    logic [LVL_W-1:0]   r_rd, n_rd;
    logic [LVL_W-1:0]   r_wr, n_wr;
    logic [LVL_W-1:0]   r_recl, n_recl;
    logic [8:0]         r_grant, n_grant;
    logic [1:0]         r_status, n_status;

    logic               in_fire, out_free, flag, cfg_wr;
    logic [LVL_W-1:0]   rd_nxt;
    logic [LVL_W:0]     tail_sum, tail, head_ext, cap_ext, off;
    logic               written;
    logic [IDX_W-1:0]   acq_slot;
    logic [IDX_W:0]     grant_full;
    logic [8:0]         rel_idx;
    logic               rel_ok;
    logic [IDX_W-1:0]   st_slot;
    logic [STAMP_W-1:0] st_stamp;
    logic               reclaim;
    logic [LVL_W-1:0]   cap_clamped;

    logic               free_we;
    logic [IDX_W-1:0]   free_waddr, free_raddr;
    logic [IDX_W-1:0]   free_wdata, free_rdata;
    logic               pend_we;
    logic [IDX_W-1:0]   pend_waddr, pend_raddr;
    logic [PEND_W-1:0]  pend_wdata, pend_rdata;

    drialloc_ram #(.WIDTH(IDX_W), .DEPTH(POOL_DEPTH)) u_free_ram (
        .i_clk   (i_clk),
        .i_we    (free_we),
        .i_waddr (free_waddr),
        .i_wdata (free_wdata),
        .i_raddr (free_raddr),
        .o_rdata (free_rdata)
    );

    drialloc_ram #(.WIDTH(PEND_W), .DEPTH(POOL_DEPTH)) u_pend_ram (
        .i_clk   (i_clk),
        .i_we    (pend_we),
        .i_waddr (pend_waddr),
        .i_wdata (pend_wdata),
        .i_raddr (pend_raddr),
        .o_rdata (pend_rdata)
    );

    assign ctrl        = drialloc_pkg::ucode(r_upc);
    assign o_in_ready  = (ctrl.cond == drialloc_pkg::CD_INPUT);
    assign in_fire     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign pready      = 1'b1;
    assign cfg_wr      = psel && penable && pwrite;

    always_comb begin
        case (paddr)
            drialloc_pkg::ADDR_ENABLED:  prdata = {31'b0, r_en};
            drialloc_pkg::ADDR_CAPACITY: prdata = 32'(r_cap);
            default:                     prdata = '0;
        endcase
    end

    always_comb begin
        if (pwdata[8:0] == 9'd0) begin
            cap_clamped = LVL_W'(1);
        end else if (32'(pwdata[8:0]) > 32'(POOL_DEPTH)) begin
            cap_clamped = LVL_W'(POOL_DEPTH);
        end else begin
            cap_clamped = LVL_W'(pwdata[8:0]);
        end
    end

    assign rd_nxt   = r_rd + LVL_W'(1);
    assign tail_sum = (LVL_W+1)'(r_head) + (LVL_W+1)'(r_free_lvl);
    assign tail     = (tail_sum >= (LVL_W+1)'(POOL_DEPTH))
                      ? tail_sum - (LVL_W+1)'(POOL_DEPTH) : tail_sum;
    assign head_ext = (LVL_W+1)'(r_head);
    assign cap_ext  = (LVL_W+1)'(r_cap);
    assign off      = (head_ext >= cap_ext) ? head_ext - cap_ext
                      : head_ext + (LVL_W+1)'(POOL_DEPTH) - cap_ext;
    assign written  = off < (LVL_W+1)'(r_fill);
    assign acq_slot = written ? free_rdata : r_head;
    assign grant_full = {1'b0, acq_slot} + (IDX_W+1)'(1);

    assign rel_idx = r_in.handle - 9'd1;
    assign rel_ok  = (r_in.handle != 9'd0) && r_en
                     && (CMP_W'(rel_idx) < CMP_W'(r_cap));

    assign st_slot  = pend_rdata[PEND_W-1:STAMP_W];
    assign st_stamp = pend_rdata[STAMP_W-1:0];
    assign reclaim  = r_in.force_all || (st_stamp <= STAMP_W'(r_in.completed_frame));

    always_comb begin
        case (ctrl.op)
            drialloc_pkg::OP_ACQ_CHECK: flag = !r_en || (r_free_lvl == '0);
            drialloc_pkg::OP_TICK_INIT: flag = (r_pend_lvl == '0);
            drialloc_pkg::OP_TICK_STEP: flag = (rd_nxt == r_pend_lvl);
            default:                    flag = 1'b0;
        endcase
    end

    always_comb begin
        case (ctrl.cond)
            drialloc_pkg::CD_NEXT:   n_upc = r_upc + 4'd1;
            drialloc_pkg::CD_JUMP:   n_upc = ctrl.target;
            drialloc_pkg::CD_FLAG:   n_upc = flag ? ctrl.target : r_upc + 4'd1;
            drialloc_pkg::CD_LOOP:   n_upc = flag ? r_upc + 4'd1 : ctrl.target;
            drialloc_pkg::CD_OUTPUT: n_upc = out_free ? ctrl.target : r_upc;
            drialloc_pkg::CD_INPUT: begin
                if (!in_fire) begin
                    n_upc = r_upc;
                end else begin
                    case (i_in.kind)
                        drialloc_pkg::KIND_ACQUIRE: n_upc = drialloc_pkg::UA_ACQ_CHK;
                        drialloc_pkg::KIND_RELEASE: n_upc = drialloc_pkg::UA_REL;
                        drialloc_pkg::KIND_TICK:    n_upc = drialloc_pkg::UA_TICK_INIT;
                        default:                    n_upc = drialloc_pkg::UA_BAD;
                    endcase
                end
            end
            default:                 n_upc = drialloc_pkg::UA_FETCH;
        endcase
    end

    always_comb begin
        n_in        = r_in;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        n_en        = r_en;
        n_cap       = r_cap;
        n_head      = r_head;
        n_free_lvl  = r_free_lvl;
        n_fill      = r_fill;
        n_pend_lvl  = r_pend_lvl;
        n_rd        = r_rd;
        n_wr        = r_wr;
        n_recl      = r_recl;
        n_grant     = r_grant;
        n_status    = r_status;
        free_we     = 1'b0;
        free_waddr  = IDX_W'(tail);
        free_wdata  = st_slot;
        free_raddr  = r_head;
        pend_we     = 1'b0;
        pend_waddr  = r_pend_lvl[IDX_W-1:0];
        pend_wdata  = {IDX_W'(rel_idx), STAMP_W'(r_in.current_frame)};
        pend_raddr  = '0;

        case (ctrl.op)
            drialloc_pkg::OP_LATCH: begin
                if (in_fire) begin
                    n_in     = i_in;
                    n_grant  = '0;
                    n_status = drialloc_pkg::ST_OK;
                    n_recl   = '0;
                end
            end
            drialloc_pkg::OP_ACQ_CHECK: begin
                if (!r_en) begin
                    n_status = drialloc_pkg::ST_IGNORED;
                end else if (r_free_lvl == '0) begin
                    n_status = drialloc_pkg::ST_EMPTY;
                end
            end
            drialloc_pkg::OP_ACQ_GRANT: begin
                n_grant    = 9'(grant_full);
                n_head     = (r_head == IDX_W'(POOL_DEPTH - 1)) ? '0 : r_head + IDX_W'(1);
                n_free_lvl = r_free_lvl - LVL_W'(1);
            end
            drialloc_pkg::OP_REL: begin
                if (!rel_ok) begin
                    n_status = drialloc_pkg::ST_IGNORED;
                end else if (r_pend_lvl == LVL_W'(POOL_DEPTH)) begin
                    n_status = drialloc_pkg::ST_DROPPED;
                end else begin
                    pend_we    = 1'b1;
                    n_pend_lvl = r_pend_lvl + LVL_W'(1);
                end
            end
            drialloc_pkg::OP_TICK_INIT: begin
                n_rd = '0;
                n_wr = '0;
            end
            drialloc_pkg::OP_TICK_STEP: begin
                if (reclaim) begin
                    if (r_free_lvl < LVL_W'(POOL_DEPTH)) begin
                        free_we    = 1'b1;
                        n_free_lvl = r_free_lvl + LVL_W'(1);
                        n_recl     = r_recl + LVL_W'(1);
                        if (r_fill < LVL_W'(POOL_DEPTH)) begin
                            n_fill = r_fill + LVL_W'(1);
                        end
                    end
                end else begin
                    pend_we    = 1'b1;
                    pend_waddr = r_wr[IDX_W-1:0];
                    pend_wdata = pend_rdata;
                    n_wr       = r_wr + LVL_W'(1);
                end
                n_rd = rd_nxt;
                if (!flag) begin
                    pend_raddr = rd_nxt[IDX_W-1:0];
                end
            end
            drialloc_pkg::OP_TICK_END: begin
                n_pend_lvl = r_wr;
            end
            drialloc_pkg::OP_BAD: begin
                n_status = drialloc_pkg::ST_IGNORED;
            end
            drialloc_pkg::OP_EMIT: begin
                if (out_free) begin
                    n_out_valid           = 1'b1;
                    n_out.granted_handle  = r_grant;
                    n_out.status          = r_status;
                    n_out.reclaimed_count = 9'(r_recl);
                    n_out.free_count      = 9'(r_free_lvl);
                    n_out.pending_count   = 9'(r_pend_lvl);
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr) begin
            case (paddr)
                drialloc_pkg::ADDR_ENABLED: begin
                    n_en = pwdata[0];
                end
                drialloc_pkg::ADDR_CAPACITY: begin
                    n_cap      = cap_clamped;
                    n_head     = '0;
                    n_free_lvl = cap_clamped;
                    n_fill     = '0;
                    n_pend_lvl = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc       <= drialloc_pkg::UA_FETCH;
            r_out_valid <= 1'b0;
            r_en        <= 1'b1;
            r_cap       <= LVL_W'(CAP_RST);
            r_head      <= '0;
            r_free_lvl  <= LVL_W'(CAP_RST);
            r_fill      <= '0;
            r_pend_lvl  <= '0;
        end else begin
            r_upc       <= n_upc;
            r_out_valid <= n_out_valid;
            r_en        <= n_en;
            r_cap       <= n_cap;
            r_head      <= n_head;
            r_free_lvl  <= n_free_lvl;
            r_fill      <= n_fill;
            r_pend_lvl  <= n_pend_lvl;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in     <= n_in;
        r_out    <= n_out;
        r_rd     <= n_rd;
        r_wr     <= n_wr;
        r_recl   <= n_recl;
        r_grant  <= n_grant;
        r_status <= n_status;
    end

endmodule
